>>> hdl/erdef_pkg.sv
// ----------------------------------------------------------------------------
// erdef_pkg: shared definitions for the event record deframer
// Phase codes, marker words, swap modes, register indexes, result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package erdef_pkg;

  // record phase
  typedef enum logic [1:0] {
    PH_COUNT  = 2'd0,
    PH_MARKER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  // old format swap rule
  typedef enum logic [1:0] {
    SWAP_CHECK  = 2'd0,
    SWAP_ALWAYS = 2'd1,
    SWAP_NEVER  = 2'd2,
    SWAP_UNUSED = 2'd3
  } swap_mode_t;

  // configuration register indexes
  localparam logic CFG_OLD_FORMAT = 1'b0;
  localparam logic CFG_SWAP_MODE  = 1'b1;

  // endian markers and masks
  localparam logic [31:0] MARK_NATIVE  = 32'h1234_5678;
  localparam logic [31:0] MARK_SWAPPED = 32'h7856_3412;
  localparam logic [31:0] HALF_MASK    = 32'hffff_0000;

  // result queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one result word
  typedef struct packed {
    logic [31:0] data;
    logic        last;
    logic        err;
  } result_t;

  // reverse the byte order of a word
  function automatic logic [31:0] byte_swap(input logic [31:0] w);
    byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

`default_nettype wire

>>> hdl/event_record_deframer_endian_fix.sv
// ----------------------------------------------------------------------------
// event_record_deframer_endian_fix: event record deframer with endian fix
// Cuts a raw word stream into records, fixes byte order per record from the
// endian marker or the old format swap rule, and flags the last word.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  ------    ---------  --------------------  ---------------------------------
//  in        input      in_valid / in_stall   raw_word, discard
//  out       output     out_valid / out_stall data_word, last_word, endian_error
//  cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One input word is taken per cycle while in_stall is low; its results (none,
//  one or two) are written into a four entry result queue in the same cycle and
//  leave it one per cycle while out_stall is low, so a marker word's two
//  results are balanced by the count word before it. in_stall rises only while
//  the queue holds more than two words. Reset (rst, synchronous) empties the
//  queue, clears both registers and returns to waiting for a count word.
//  cfg_ready is always high.
`default_nettype none

module event_record_deframer_endian_fix (
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] raw_word,
  input  wire logic        discard,
  // result words
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      data_word,
  output logic             last_word,
  output logic             endian_error,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data
);

  // configuration registers
  logic                   old_format;
  erdef_pkg::swap_mode_t  swap_mode;

  // record state
  erdef_pkg::phase_t phase, phase_next;
  logic [31:0]       held_count_word, held_count_word_next;
  logic [31:0]       words_left, words_left_next;
  logic              swap_flag, swap_flag_next;

  // results of the current word
  logic [1:0]          res_num;
  erdef_pkg::result_t  res0, res1;

  // result queue
  erdef_pkg::result_t               queue [erdef_pkg::QUEUE_DEPTH];
  logic [erdef_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [erdef_pkg::QCNT_W-1:0]     fill;

  logic in_fire, out_fire, cfg_fire;
  logic [erdef_pkg::QCNT_W-1:0] push_cnt, pop_cnt;

  // handshakes
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_stall  = fill > erdef_pkg::QCNT_W'(2);
  assign in_fire   = in_valid & ~in_stall;
  assign out_valid = fill != '0;
  assign out_fire  = out_valid & ~out_stall;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      old_format <= 1'b0;
      swap_mode  <= erdef_pkg::SWAP_CHECK;
    end else if (cfg_fire) begin
      case (cfg_index)
        erdef_pkg::CFG_OLD_FORMAT: old_format <= cfg_data[0];
        erdef_pkg::CFG_SWAP_MODE:  swap_mode  <= erdef_pkg::swap_mode_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // next state of the record
  always_comb begin
    logic [31:0] cnt;
    logic        swap;
    erdef_pkg::phase_t ph;
    phase_next           = phase;
    held_count_word_next = held_count_word;
    words_left_next      = words_left;
    swap_flag_next       = swap_flag;
    ph                   = discard ? erdef_pkg::PH_COUNT : phase;
    cnt                  = '0;
    swap                 = 1'b0;
    if (discard) begin
      words_left_next = '0;
    end
    case (ph)
      erdef_pkg::PH_COUNT: begin
        held_count_word_next = raw_word;
        if (!old_format) begin
          phase_next = erdef_pkg::PH_MARKER;
        end else begin
          case (swap_mode)
            erdef_pkg::SWAP_CHECK:  swap = (raw_word & erdef_pkg::HALF_MASK) != '0;
            erdef_pkg::SWAP_ALWAYS: swap = 1'b1;
            default:                swap = 1'b0;
          endcase
          swap_flag_next  = swap;
          cnt             = swap ? erdef_pkg::byte_swap(raw_word) : raw_word;
          words_left_next = cnt;
          phase_next      = (cnt == '0) ? erdef_pkg::PH_COUNT : erdef_pkg::PH_BODY;
        end
      end
      erdef_pkg::PH_MARKER: begin
        if (raw_word == erdef_pkg::MARK_NATIVE || raw_word == erdef_pkg::MARK_SWAPPED) begin
          swap            = raw_word == erdef_pkg::MARK_SWAPPED;
          swap_flag_next  = swap;
          cnt             = swap ? erdef_pkg::byte_swap(held_count_word) : held_count_word;
          words_left_next = (cnt != '0) ? cnt - 32'd1 : '0;
          phase_next      = (cnt <= 32'd1) ? erdef_pkg::PH_COUNT : erdef_pkg::PH_BODY;
        end else begin
          words_left_next = '0;
          phase_next      = erdef_pkg::PH_COUNT;
        end
      end
      erdef_pkg::PH_BODY: begin
        words_left_next = (words_left != '0) ? words_left - 32'd1 : '0;
        phase_next      = (words_left <= 32'd1) ? erdef_pkg::PH_COUNT : erdef_pkg::PH_BODY;
      end
      default: begin
        phase_next = erdef_pkg::PH_COUNT;
      end
    endcase
  end

  // result words of the current input word
  always_comb begin
    logic [31:0] cnt;
    logic        swap;
    erdef_pkg::phase_t ph;
    ph      = discard ? erdef_pkg::PH_COUNT : phase;
    res_num = 2'd0;
    res0    = '0;
    res1    = '0;
    cnt     = '0;
    swap    = 1'b0;
    case (ph)
      erdef_pkg::PH_COUNT: begin
        if (old_format) begin
          case (swap_mode)
            erdef_pkg::SWAP_CHECK:  swap = (raw_word & erdef_pkg::HALF_MASK) != '0;
            erdef_pkg::SWAP_ALWAYS: swap = 1'b1;
            default:                swap = 1'b0;
          endcase
          cnt       = swap ? erdef_pkg::byte_swap(raw_word) : raw_word;
          res_num   = 2'd1;
          res0.data = cnt;
          res0.last = cnt == '0;
        end
      end
      erdef_pkg::PH_MARKER: begin
        if (raw_word == erdef_pkg::MARK_NATIVE || raw_word == erdef_pkg::MARK_SWAPPED) begin
          swap      = raw_word == erdef_pkg::MARK_SWAPPED;
          cnt       = swap ? erdef_pkg::byte_swap(held_count_word) : held_count_word;
          res_num   = 2'd2;
          res0.data = cnt;
          res1.data = swap ? erdef_pkg::byte_swap(raw_word) : raw_word;
          res1.last = cnt <= 32'd1;
        end else begin
          res_num   = 2'd1;
          res0.data = raw_word;
          res0.err  = 1'b1;
        end
      end
      erdef_pkg::PH_BODY: begin
        res_num   = 2'd1;
        res0.data = swap_flag ? erdef_pkg::byte_swap(raw_word) : raw_word;
        res0.last = words_left <= 32'd1;
      end
      default: ;
    endcase
  end

  // record state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= erdef_pkg::PH_COUNT;
      held_count_word <= '0;
      words_left      <= '0;
      swap_flag       <= 1'b0;
    end else if (in_fire) begin
      phase           <= phase_next;
      held_count_word <= held_count_word_next;
      words_left      <= words_left_next;
      swap_flag       <= swap_flag_next;
    end
  end

  // queue pointers and fill level
  assign push_cnt = in_fire ? erdef_pkg::QCNT_W'(res_num) : '0;
  assign pop_cnt  = erdef_pkg::QCNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + erdef_pkg::QPTR_W'(push_cnt);
      rd_ptr <= rd_ptr + erdef_pkg::QPTR_W'(pop_cnt);
      fill   <= fill + push_cnt - pop_cnt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (in_fire && res_num != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (in_fire && res_num == 2'd2) begin
      queue[wr_ptr + erdef_pkg::QPTR_W'(1)] <= res1;
    end
  end

  // head of the queue drives the result port
  assign data_word    = queue[rd_ptr].data;
  assign last_word    = queue[rd_ptr].last;
  assign endian_error = queue[rd_ptr].err;

endmodule

`default_nettype wire

>>> dv/event_record_deframer_endian_fix_test.sv
// ----------------------------------------------------------------------------
// event_record_deframer_endian_fix_test: self-checking bench for the deframer
// Drives raw stream words through a short directed table, then through random
// records in both header formats, predicts result words that no table row gives
// with a behavioral copy of the deframer, and compares results field by field.
// ----------------------------------------------------------------------------

module event_record_deframer_endian_fix_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 750;
  localparam int DRAIN_GAP    = 4;
  localparam int PREDICTED    = -1;
  localparam int CALM_FROM    = 320;
  localparam int CALM_LEN     = 150;
  localparam int PAUSE_AT     = 560;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t           kind;
    logic                idx;
    logic [1:0]          val;
    logic [31:0]         w;
    logic                d;
    int                  n;
    erdef_pkg::result_t  e0;
    erdef_pkg::result_t  e1;
  } step_row_t;

  logic        clk;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [31:0] raw_word     = '0;
  logic        discard      = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [31:0] data_word;
  logic        last_word;
  logic        endian_error;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic        cfg_index    = 1'b0;
  logic [1:0]  cfg_data     = '0;

  // deframer state as predicted
  erdef_pkg::phase_t     rec_phase  = erdef_pkg::PH_COUNT;
  logic [31:0]           held_count = '0;
  logic [32:0]           left_count = '0;
  logic                  swap_on    = 1'b0;
  logic                  old_fmt    = 1'b0;
  erdef_pkg::swap_mode_t swap_rule  = erdef_pkg::SWAP_CHECK;

  erdef_pkg::result_t  record_words_due[$];
  step_row_t           plan[$];

  int          cycle_count    = 0;
  int          words_in       = 0;
  int          results_seen   = 0;
  int          records_closed = 0;
  int          marker_errors  = 0;
  int          cfg_writes     = 0;
  int          mismatches     = 0;
  bit          calm           = 1'b0;

  event_record_deframer_endian_fix dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_word     (raw_word),
    .discard      (discard),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_word    (data_word),
    .last_word    (last_word),
    .endian_error (endian_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit roll_idle();
    return !calm && ($urandom_range(0, 99) < 28);
  endfunction

  function automatic logic [31:0] reorder_bytes(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] in_host_order(input logic [31:0] x);
    return swap_on ? reorder_bytes(x) : x;
  endfunction

  // advance the predicted deframer by one stream word
  task automatic deframe_word(input logic [31:0] w, input logic d, output int n,
                              output erdef_pkg::result_t r0,
                              output erdef_pkg::result_t r1);
    logic [31:0] cnt;
    logic        fin;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (d) begin
      rec_phase  = erdef_pkg::PH_COUNT;
      left_count = '0;
    end
    case (rec_phase)
      erdef_pkg::PH_COUNT: begin
        held_count = w;
        if (!old_fmt) begin
          rec_phase = erdef_pkg::PH_MARKER;
        end else begin
          case (swap_rule)
            erdef_pkg::SWAP_CHECK:  swap_on = |(w & erdef_pkg::HALF_MASK);
            erdef_pkg::SWAP_ALWAYS: swap_on = 1'b1;
            default:                swap_on = 1'b0;
          endcase
          cnt        = in_host_order(w);
          left_count = {1'b0, cnt};
          fin        = (cnt == '0);
          rec_phase  = fin ? erdef_pkg::PH_COUNT : erdef_pkg::PH_BODY;
          n          = 1;
          r0         = {cnt, fin, 1'b0};
        end
      end
      erdef_pkg::PH_MARKER: begin
        if (w == erdef_pkg::MARK_NATIVE || w == erdef_pkg::MARK_SWAPPED) begin
          swap_on    = (w == erdef_pkg::MARK_SWAPPED);
          cnt        = in_host_order(held_count);
          left_count = (cnt != '0) ? {1'b0, cnt} - 33'd1 : '0;
          fin        = (left_count == '0);
          rec_phase  = fin ? erdef_pkg::PH_COUNT : erdef_pkg::PH_BODY;
          n          = 2;
          r0         = {cnt, 1'b0, 1'b0};
          r1         = {in_host_order(w), fin, 1'b0};
        end else begin
          // unknown marker drops the record
          rec_phase  = erdef_pkg::PH_COUNT;
          left_count = '0;
          n          = 1;
          r0         = {w, 1'b0, 1'b1};
        end
      end
      default: begin
        if (left_count != '0) left_count = left_count - 33'd1;
        fin = (left_count == '0);
        if (fin) rec_phase = erdef_pkg::PH_COUNT;
        n  = 1;
        r0 = {in_host_order(w), fin, 1'b0};
      end
    endcase
  endtask

  // hand one word to the block; called and returning at a falling edge
  task automatic send_word(input logic [31:0] w, input logic d,
                           input int n_typed = PREDICTED,
                           input erdef_pkg::result_t t0 = '0,
                           input erdef_pkg::result_t t1 = '0);
    int                  n;
    erdef_pkg::result_t  r0;
    erdef_pkg::result_t  r1;
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_word <= w;
    discard  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_in++;
    deframe_word(w, d, n, r0, r1);
    if (n_typed != PREDICTED) begin
      n  = n_typed;
      r0 = t0;
      r1 = t1;
    end
    if (n > 0) record_words_due.push_back(r0);
    if (n > 1) record_words_due.push_back(r1);
    @(negedge clk);
  endtask

  // stop sending and let every outstanding result word come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (record_words_due.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == erdef_pkg::CFG_OLD_FORMAT) old_fmt = val[0];
    else swap_rule = erdef_pkg::swap_mode_t'(val);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic step_row_t word_row(input logic [31:0] w, input logic d, input int n,
                                         input erdef_pkg::result_t e0 = '0,
                                         input erdef_pkg::result_t e1 = '0);
    step_row_t r;
    r.kind = ROW_WORD;
    r.idx  = 1'b0;
    r.val  = '0;
    r.w    = w;
    r.d    = d;
    r.n    = n;
    r.e0   = e0;
    r.e1   = e1;
    return r;
  endfunction

  function automatic step_row_t cfg_row(input logic idx, input logic [1:0] val);
    step_row_t r;
    r      = word_row('0, 1'b0, 0);
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= roll_idle();
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    erdef_pkg::result_t got;
    erdef_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {data_word, last_word, endian_error};
      results_seen++;
      if (last_word) records_closed++;
      if (endian_error) marker_errors++;
      if (record_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: data %h last %b err %b",
                   got.data, got.last, got.err);
      end else begin
        want = record_words_due.pop_front();
        if (got.data !== want.data || got.last !== want.last || got.err !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected data %h last %b err %b, got data %h last %b err %b",
                     results_seen, want.data, want.last, want.err,
                     got.data, got.last, got.err);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result words still due",
               cycle_count, record_words_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int          roll;
    int          body;
    int          next_cfg_at;
    logic [31:0] cnt;
    logic [31:0] count_raw;
    logic [31:0] marker;
    logic        start_d;
    logic        flip;
    bit          paused;

    // directed table: count word, marker and body cases in both formats
    plan.push_back(word_row(32'h0000_0002, 1'b0, 0));
    plan.push_back(word_row(erdef_pkg::MARK_NATIVE, 1'b0, 2, {32'h2, 1'b0, 1'b0},
                            {erdef_pkg::MARK_NATIVE, 1'b0, 1'b0}));
    plan.push_back(word_row(32'hffff_ffff, 1'b0, 1, {32'hffff_ffff, 1'b1, 1'b0}));
    // zero count ends the record at the marker
    plan.push_back(word_row(32'h0, 1'b0, 0));
    plan.push_back(word_row(erdef_pkg::MARK_SWAPPED, 1'b0, 2, {32'h0, 1'b0, 1'b0},
                            {erdef_pkg::MARK_NATIVE, 1'b1, 1'b0}));
    // count of one also ends at the marker
    plan.push_back(word_row(32'h0100_0000, 1'b0, 0));
    plan.push_back(word_row(erdef_pkg::MARK_SWAPPED, 1'b0, 2, {32'h1, 1'b0, 1'b0},
                            {erdef_pkg::MARK_NATIVE, 1'b1, 1'b0}));
    // unknown marker
    plan.push_back(word_row(32'h0000_0005, 1'b0, 0));
    plan.push_back(word_row(32'hdead_beef, 1'b0, 1, {32'hdead_beef, 1'b0, 1'b1}));
    // largest count, then cut short by a discard
    plan.push_back(word_row(32'hffff_ffff, 1'b0, 0));
    plan.push_back(word_row(erdef_pkg::MARK_NATIVE, 1'b0, 2, {32'hffff_ffff, 1'b0, 1'b0},
                            {erdef_pkg::MARK_NATIVE, 1'b0, 1'b0}));
    plan.push_back(word_row(32'ha5a5_a5a5, 1'b1, 0));
    plan.push_back(word_row(erdef_pkg::MARK_NATIVE, 1'b0, PREDICTED));
    plan.push_back(word_row(32'h0, 1'b1, 0));
    plan.push_back(word_row(32'h0, 1'b0, 1, {32'h0, 1'b0, 1'b1}));
    // old format, swap decided by the upper half
    plan.push_back(cfg_row(erdef_pkg::CFG_OLD_FORMAT, 2'd1));
    plan.push_back(word_row(32'h0300_0000, 1'b0, 1, {32'h3, 1'b0, 1'b0}));
    plan.push_back(word_row(32'h1122_3344, 1'b0, PREDICTED));
    plan.push_back(word_row(32'h55aa_55aa, 1'b0, PREDICTED));
    plan.push_back(word_row(32'h8000_0001, 1'b0, 1, {32'h0100_0080, 1'b1, 1'b0}));
    plan.push_back(cfg_row(erdef_pkg::CFG_SWAP_MODE, erdef_pkg::SWAP_ALWAYS));
    plan.push_back(word_row(32'h0, 1'b0, 1, {32'h0, 1'b1, 1'b0}));
    plan.push_back(cfg_row(erdef_pkg::CFG_SWAP_MODE, erdef_pkg::SWAP_NEVER));
    plan.push_back(word_row(32'h1, 1'b0, 1, {32'h1, 1'b0, 1'b0}));
    // the unused swap rule, changed while a record is open, acts as never
    plan.push_back(cfg_row(erdef_pkg::CFG_SWAP_MODE, erdef_pkg::SWAP_UNUSED));
    plan.push_back(word_row(32'hcafe_f00d, 1'b0, 1, {32'hcafe_f00d, 1'b1, 1'b0}));
    plan.push_back(word_row(32'hffff_0000, 1'b0, 1, {32'hffff_0000, 1'b0, 1'b0}));
    // format flips back while the record is open
    plan.push_back(cfg_row(erdef_pkg::CFG_OLD_FORMAT, 2'd0));
    plan.push_back(word_row(32'h7fff_ffff, 1'b0, PREDICTED));
    plan.push_back(word_row(32'h1234_5678, 1'b1, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_word(plan[i].w, plan[i].d, plan[i].n, plan[i].e0, plan[i].e1);
      end
    end

    // random records, mostly well formed
    write_reg(erdef_pkg::CFG_OLD_FORMAT, 2'd1);
    write_reg(erdef_pkg::CFG_SWAP_MODE, erdef_pkg::SWAP_CHECK);
    next_cfg_at = words_in + $urandom_range(60, 140);
    paused      = 1'b0;
    while (words_in < plan.size() + RANDOM_WORDS) begin
      if (words_in >= next_cfg_at) begin
        write_reg(erdef_pkg::CFG_OLD_FORMAT, 2'($urandom_range(0, 1)));
        write_reg(erdef_pkg::CFG_SWAP_MODE, 2'($urandom_range(0, 3)));
        next_cfg_at = words_in + $urandom_range(60, 140);
      end
      calm = (words_in >= CALM_FROM) && (words_in < CALM_FROM + CALM_LEN);
      if (!paused && words_in >= PAUSE_AT) begin
        wait_drained();
        paused = 1'b1;
      end

      roll    = $urandom_range(0, 99);
      start_d = (rec_phase != erdef_pkg::PH_COUNT) || ($urandom_range(0, 15) == 0);
      if (roll < 85) begin
        // record with a small count, sometimes a bad marker or cut short
        cnt  = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(7, 40))
                                           : 32'($urandom_range(0, 6));
        flip = 1'($urandom_range(0, 1));
        if (!old_fmt) begin
          send_word(flip ? reorder_bytes(cnt) : cnt, start_d);
          marker = (roll < 8) ? $urandom
                              : (flip ? erdef_pkg::MARK_SWAPPED : erdef_pkg::MARK_NATIVE);
          send_word(marker, 1'b0);
          body = (roll < 8 || cnt == '0) ? 0 : int'(cnt) - 1;
        end else begin
          case (swap_rule)
            erdef_pkg::SWAP_CHECK:  count_raw = flip ? reorder_bytes(cnt) : cnt;
            erdef_pkg::SWAP_ALWAYS: count_raw = reorder_bytes(cnt);
            default:                count_raw = cnt;
          endcase
          send_word(count_raw, start_d);
          body = int'(cnt);
        end
        if (roll >= 75) body = $urandom_range(0, body);
        repeat (body) send_word($urandom, 1'($urandom_range(0, 49) == 0));
      end else if (roll < 93) begin
        // raw count word with any value, abandoned after a few words
        send_word($urandom, start_d);
        repeat ($urandom_range(0, 4)) send_word($urandom, 1'b0);
      end else begin
        send_word($urandom, 1'($urandom_range(0, 1)));
      end
    end
    calm = 1'b0;

    wait_drained();
    if (record_words_due.size() != 0) begin
      mismatches += record_words_due.size();
      $display("%0d expected result words never arrived", record_words_due.size());
    end

    $display("covered %0d stream words, %0d result words checked, %0d records closed",
             words_in, results_seen, records_closed);
    $display("%0d marker errors seen, %0d register writes, %0d mismatches",
             marker_errors, cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/erdef_pkg.sv
hdl/event_record_deframer_endian_fix.sv
dv/event_record_deframer_endian_fix_test.sv
